>>> hdl/rfla_pkg.sv
// Package for the record free-list allocator: field widths, action and
// status codes, default sizes and the controller command word.
// No dependencies.
`timescale 1ns / 1ps

package rfla_pkg;

   // Payload field widths
   localparam int ACTION_W = 2;
   localparam int FILE_W   = 2;
   localparam int REC_W    = 10;
   localparam int STATUS_W = 2;

   // Default sizes handed to the top level
   localparam int DEF_NUM_FILES   = 4;
   localparam int DEF_MAX_RECORDS = 1023;

   // Action codes
   localparam logic [ACTION_W-1:0] ACT_ALLOC = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_FREE  = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_RESET = 2'd2;
   localparam logic [ACTION_W-1:0] ACT_NOP   = 2'd3;

   // Status codes
   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic accept;   // capture request word, launch link read
      logic commit;   // apply list update, load result word
   } ctrl_cmd_type;

endpackage

>>> hdl/rfla_ifs.sv
// Valid/ready channel interfaces for the request and result words.
// Depends on rfla_pkg.
`timescale 1ns / 1ps

interface rfla_req_if;
   import rfla_pkg::*;

   logic                valid;
   logic                ready;
   logic [ACTION_W-1:0] action;
   logic [FILE_W-1:0]   file_index;
   logic [REC_W-1:0]    record_number;

   modport source (output valid, action, file_index, record_number, input ready);
   modport sink   (input valid, action, file_index, record_number, output ready);
endinterface

interface rfla_rsp_if;
   import rfla_pkg::*;

   logic                valid;
   logic                ready;
   logic [REC_W-1:0]    granted_record;
   logic [STATUS_W-1:0] status;

   modport source (output valid, granted_record, status, input ready);
   modport sink   (input valid, granted_record, status, output ready);
endinterface

>>> hdl/rfla_ctrl.sv
// Controller for the allocator: two-state sequencer that takes a request
// word, runs it through the datapath and owns the result valid flag.
// Depends on rfla_pkg.
`timescale 1ns / 1ps

module rfla_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rfla_pkg::ctrl_cmd_type cmd
);
   import rfla_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_EXEC = 2'b10
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   // Decode handshakes into datapath commands
   always_comb begin
      req_ready  = (state_ff == S_IDLE);
      cmd.accept = req_valid && req_ready;
      cmd.commit = (state_ff == S_EXEC) && (!rsp_valid_ff || rsp_ready);
   end

   // Advance the sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (cmd.accept) state_in = S_EXEC;
         end
         S_EXEC: begin
            if (cmd.commit) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Hold the result word until the sink takes it
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

`ifndef SYNTH
   a_accept_to_exec: assert property (@(posedge clock) disable iff (reset)
      cmd.accept |=> state_ff == S_EXEC)
      else $error("accepted word did not enter execute");

   a_commit_shows_result: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> (rsp_valid_ff && state_ff == S_IDLE))
      else $error("commit did not present a result word");

   a_exec_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EXEC && !cmd.commit) |=> state_ff == S_EXEC)
      else $error("execute left without commit");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |-> !cmd.commit)
      else $error("result word overwritten while stalled");
`endif

endmodule

>>> hdl/rfla_dpath.sv
// Datapath for the allocator: per-file free-list heads and high-water
// marks, the link memory and the result word register.
// Depends on rfla_pkg.
`timescale 1ns / 1ps

module rfla_dpath #(
   parameter int NUM_FILES   = rfla_pkg::DEF_NUM_FILES,
   parameter int MAX_RECORDS = rfla_pkg::DEF_MAX_RECORDS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  rfla_pkg::ctrl_cmd_type          cmd,
   input  logic [rfla_pkg::ACTION_W-1:0]   req_action,
   input  logic [rfla_pkg::FILE_W-1:0]     req_file_index,
   input  logic [rfla_pkg::REC_W-1:0]      req_record_number,
   output logic [rfla_pkg::REC_W-1:0]      rsp_granted_record,
   output logic [rfla_pkg::STATUS_W-1:0]   rsp_status
);
   import rfla_pkg::*;

   localparam int FIDX_W    = (NUM_FILES > 1) ? $clog2(NUM_FILES) : 1;
   localparam int HW_W      = $clog2(MAX_RECORDS + 2);
   localparam int SLOT_RAW  = $clog2(MAX_RECORDS + 1);
   localparam int SLOT_W    = (SLOT_RAW < REC_W) ? SLOT_RAW : REC_W;
   localparam int MEM_DEPTH = NUM_FILES << SLOT_W;
   localparam int ADDR_W    = $clog2(MEM_DEPTH);
   localparam int CMP_W     = (HW_W > REC_W) ? HW_W : REC_W;
   localparam int FCMP_W    = 5;

   // Request word, captured at accept
   logic [ACTION_W-1:0] act_ff;
   logic [FILE_W-1:0]   file_ff;
   logic [REC_W-1:0]    rec_ff;

   // Per-file list state
   logic [REC_W-1:0] head_ff [NUM_FILES];
   logic [HW_W-1:0]  hw_ff   [NUM_FILES];

   // Link memory: next free record for each freed record
   logic [REC_W-1:0] link_mem_ff [MEM_DEPTH];
   logic [REC_W-1:0] link_rd_ff;

   // Result word
   logic [REC_W-1:0]    granted_ff, granted_in;
   logic [STATUS_W-1:0] status_ff, status_in;

   logic [FILE_W-1:0] file_sel;
   logic [FIDX_W-1:0] fidx;
   logic [REC_W-1:0]  head_cur, head_in;
   logic [HW_W-1:0]   hw_cur, hw_in;
   logic              head_we, hw_we, link_we, file_ok;
   logic [ADDR_W-1:0] rd_addr, wr_addr;

   // One read port into the file state: new request at accept, held one otherwise
   always_comb begin
      file_sel = cmd.accept ? req_file_index : file_ff;
      fidx     = FIDX_W'(file_sel);
      head_cur = head_ff[fidx];
      hw_cur   = hw_ff[fidx];
      file_ok  = FCMP_W'(file_ff) < FCMP_W'(NUM_FILES);
      rd_addr  = (ADDR_W'(fidx) << SLOT_W) | ADDR_W'(head_cur[SLOT_W-1:0]);
      wr_addr  = (ADDR_W'(fidx) << SLOT_W) | ADDR_W'(rec_ff[SLOT_W-1:0]);
   end

   // Decide the result and the list update for the held word
   always_comb begin
      granted_in = '0;
      status_in  = ST_OK;
      head_in    = head_cur;
      hw_in      = hw_cur;
      head_we    = 1'b0;
      hw_we      = 1'b0;
      link_we    = 1'b0;
      if (act_ff != ACT_NOP && !file_ok) begin
         status_in = ST_RANGE;
      end else begin
         unique case (act_ff)
            ACT_ALLOC: begin
               if (head_cur != '0) begin
                  // pop the free list
                  granted_in = head_cur;
                  head_in    = link_rd_ff;
                  head_we    = 1'b1;
               end else if (hw_cur <= HW_W'(MAX_RECORDS)) begin
                  // hand out a fresh record
                  granted_in = REC_W'(hw_cur);
                  hw_in      = hw_cur + HW_W'(1);
                  hw_we      = 1'b1;
               end else begin
                  status_in = ST_FULL;
               end
            end
            ACT_FREE: begin
               if (rec_ff == '0 || CMP_W'(rec_ff) >= CMP_W'(hw_cur)) begin
                  status_in = ST_RANGE;
               end else begin
                  // push in front of the old head
                  link_we = 1'b1;
                  head_in = rec_ff;
                  head_we = 1'b1;
               end
            end
            ACT_RESET: begin
               head_in = '0;
               hw_in   = HW_W'(1);
               head_we = 1'b1;
               hw_we   = 1'b1;
            end
            default: ;
         endcase
      end
   end

   // Capture request word
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         act_ff  <= req_action;
         file_ff <= req_file_index;
         rec_ff  <= req_record_number;
      end
   end

   // Update per-file heads and marks
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_FILES; i++) begin
            head_ff[i] <= '0;
            hw_ff[i]   <= HW_W'(1);
         end
      end else if (cmd.commit) begin
         if (head_we) head_ff[fidx] <= head_in;
         if (hw_we) hw_ff[fidx] <= hw_in;
      end
   end

   // Link memory: read at accept, write on a committed free
   always_ff @(posedge clock) begin
      if (cmd.accept) link_rd_ff <= link_mem_ff[rd_addr];
      if (cmd.commit && link_we) link_mem_ff[wr_addr] <= head_cur;
   end

   // Load result word
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         granted_ff <= granted_in;
         status_ff  <= status_in;
      end
   end

   assign rsp_granted_record = granted_ff;
   assign rsp_status         = status_ff;

endmodule

>>> hdl/record_free_list_allocator_unit.sv
// Top level of the record free-list allocator: joins the controller and
// the datapath to the request and result channels.
// Depends on rfla_pkg, rfla_ifs, rfla_ctrl and rfla_dpath.
//
//   channel   dir   fields                               handshake
//   req_chan  in    action, file_index, record_number    valid/ready
//   rsp_chan  out   granted_record, status               valid/ready
//
// For each word, the accept cycle reads the file's list head and launches
// the registered link memory read; the word then commits from execute
// once the result slot is free.
// Reset clears the heads and high-water marks at once; the link memory
// has no clearing pass and is only read where a free has written it.
// A stalled result holds the word in execute; a new request word is
// taken while the previous result still waits.
`timescale 1ns / 1ps

module record_free_list_allocator_unit #(
   parameter int NUM_FILES   = rfla_pkg::DEF_NUM_FILES,
   parameter int MAX_RECORDS = rfla_pkg::DEF_MAX_RECORDS
) (
   input logic        clock,
   input logic        reset,
   rfla_req_if.sink   req_chan,
   rfla_rsp_if.source rsp_chan
);
   import rfla_pkg::*;

   ctrl_cmd_type cmd;

   rfla_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd)
   );

   rfla_dpath #(
      .NUM_FILES   (NUM_FILES),
      .MAX_RECORDS (MAX_RECORDS)
   ) u_dpath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .req_action         (req_chan.action),
      .req_file_index     (req_chan.file_index),
      .req_record_number  (req_chan.record_number),
      .rsp_granted_record (rsp_chan.granted_record),
      .rsp_status         (rsp_chan.status)
   );

endmodule

>>> test/rfla_alloc_checker.sv
// Checker for the record free-list allocator: watches the request and result
// channels, predicts each result word and compares it field by field.
// Depends on rfla_pkg and rfla_ifs.
`timescale 1ns / 1ps

module rfla_alloc_checker
   import rfla_pkg::*;
#(
   parameter int NUM_FILES   = DEF_NUM_FILES,
   parameter int MAX_RECORDS = DEF_MAX_RECORDS
) (
   input  logic clock,
   input  logic reset,
   rfla_req_if  req_mon,
   rfla_rsp_if  rsp_mon,
   output int   fail_count,
   output int   pending_count
);

   typedef struct packed {
      logic [REC_W-1:0]    granted;
      logic [STATUS_W-1:0] status;
   } grant_word_type;

   // Shadow allocator state
   logic [REC_W-1:0] list_head   [NUM_FILES];
   logic [REC_W:0]   next_unused [NUM_FILES];
   logic [REC_W-1:0] next_free   [NUM_FILES][1 << REC_W];

   grant_word_type expected_grants[$];
   int             mismatches;

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("[%0t] mismatch on %s: got %0d, want %0d", $time, what, got, want);
      mismatches++;
   endtask

   // Apply one request word to the shadow state and return its result word
   function automatic grant_word_type predict_grant(input logic [ACTION_W-1:0] act,
                                                    input logic [FILE_W-1:0]   fidx,
                                                    input logic [REC_W-1:0]    rec);
      grant_word_type res;
      res.granted = '0;
      res.status  = ST_OK;
      if (act != ACT_NOP && int'(fidx) >= NUM_FILES) begin
         res.status = ST_RANGE;
      end else begin
         case (act)
            ACT_ALLOC: begin
               if (list_head[fidx] != '0) begin
                  // pop the free list
                  res.granted     = list_head[fidx];
                  list_head[fidx] = next_free[fidx][res.granted];
               end else if (int'(next_unused[fidx]) <= MAX_RECORDS) begin
                  // take a fresh record and bump the mark
                  res.granted       = next_unused[fidx][REC_W-1:0];
                  next_unused[fidx] = next_unused[fidx] + 1'b1;
               end else begin
                  res.status = ST_FULL;
               end
            end
            ACT_FREE: begin
               if (rec == '0 || {1'b0, rec} >= next_unused[fidx]) begin
                  res.status = ST_RANGE;
               end else begin
                  // push in front of the old head, double frees included
                  next_free[fidx][rec] = list_head[fidx];
                  list_head[fidx]      = rec;
               end
            end
            ACT_RESET: begin
               list_head[fidx]   = '0;
               next_unused[fidx] = (REC_W+1)'(1);
            end
            default: ;
         endcase
      end
      return res;
   endfunction

   always @(posedge clock) begin
      grant_word_type want;
      if (reset) begin
         for (int f = 0; f < NUM_FILES; f++) begin
            list_head[f]   = '0;
            next_unused[f] = (REC_W+1)'(1);
         end
         expected_grants.delete();
         mismatches = 0;
      end else begin
         // check the result word against the oldest prediction
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_grants.size() == 0) begin
               report_mismatch("unexpected result word (queue depth)", 1, 0);
            end else begin
               want = expected_grants.pop_front();
               if (rsp_mon.granted_record !== want.granted)
                  report_mismatch("granted_record", int'(rsp_mon.granted_record),
                                  int'(want.granted));
               if (rsp_mon.status !== want.status)
                  report_mismatch("status", int'(rsp_mon.status), int'(want.status));
            end
         end
         // predict the accepted request word
         if (req_mon.valid && req_mon.ready)
            expected_grants.push_back(predict_grant(req_mon.action, req_mon.file_index,
                                                    req_mon.record_number));
      end
      fail_count    <= mismatches;
      pending_count <= expected_grants.size();
   end

endmodule

>>> test/tb_record_free_list_allocator_unit.sv
// Testbench top for the record free-list allocator: drives request words,
// stalls the result channel at random and gives the verdict.
// Depends on rfla_pkg, rfla_ifs, record_free_list_allocator_unit, rfla_alloc_checker.
`timescale 1ns / 1ps

module tb_record_free_list_allocator_unit;
   import rfla_pkg::*;

   localparam int NUM_FILES      = DEF_NUM_FILES;
   localparam int MAX_RECORDS    = DEF_MAX_RECORDS;
   localparam int RANDOM_WORDS   = 80;
   localparam int CALM_WORDS     = 30;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 16;

   logic clock;
   logic reset;
   bit   calm = 1'b0;
   int   idle_cycles = 0;
   int   fail_count;
   int   pending_count;

   rfla_req_if req_bus ();
   rfla_rsp_if rsp_bus ();

   record_free_list_allocator_unit #(
      .NUM_FILES   (NUM_FILES),
      .MAX_RECORDS (MAX_RECORDS)
   ) u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   rfla_alloc_checker #(
      .NUM_FILES   (NUM_FILES),
      .MAX_RECORDS (MAX_RECORDS)
   ) u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_bus),
      .rsp_mon       (rsp_bus),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Offer one request word, with an optional gap before it, and hold until taken
   task automatic send_word(input logic [ACTION_W-1:0] act,
                            input logic [FILE_W-1:0]   fidx,
                            input logic [REC_W-1:0]    rec);
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      req_bus.valid         <= 1'b1;
      req_bus.action        <= act;
      req_bus.file_index    <= fidx;
      req_bus.record_number <= rec;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
   endtask

   // Result channel back-pressure in bursts
   initial begin
      rsp_bus.ready <= 1'b0;
      repeat (8) @(posedge clock);
      forever begin
         if (!calm && $urandom_range(0, 2) == 0) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clock);
         end else begin
            rsp_bus.ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
      end
   end

   // Stop a hung run
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("[record_free_list_allocator_unit] ERROR");
         $finish;
      end
   end

   initial begin
      logic [FILE_W-1:0] fidx;
      logic [REC_W-1:0]  rec;
      int                pick;

      reset                 <= 1'b1;
      req_bus.valid         <= 1'b0;
      req_bus.action        <= ACT_NOP;
      req_bus.file_index    <= '0;
      req_bus.record_number <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed: fresh grants, range rejects, list reuse, double free, no-op, reset
      send_word(ACT_ALLOC, 2'd0, '0);
      send_word(ACT_ALLOC, 2'd0, '0);
      send_word(ACT_ALLOC, 2'd0, '0);
      send_word(ACT_FREE,  2'd0, 10'd0);
      send_word(ACT_FREE,  2'd0, 10'd4);
      send_word(ACT_FREE,  2'd0, 10'd1023);
      send_word(ACT_FREE,  2'd0, 10'd3);
      send_word(ACT_FREE,  2'd0, 10'd1);
      send_word(ACT_ALLOC, 2'd0, '1);
      send_word(ACT_ALLOC, 2'd0, '0);
      send_word(ACT_ALLOC, 2'd0, '0);
      send_word(ACT_FREE,  2'd0, 10'd2);
      send_word(ACT_FREE,  2'd0, 10'd2);
      send_word(ACT_ALLOC, 2'd0, '0);
      send_word(ACT_ALLOC, 2'd0, '0);
      send_word(ACT_NOP,   2'd3, 10'd1023);
      send_word(ACT_ALLOC, 2'd3, '0);
      send_word(ACT_RESET, 2'd0, '1);
      send_word(ACT_ALLOC, 2'd0, '0);
      send_word(ACT_FREE,  2'd1, 10'd1);
      send_word(ACT_RESET, 2'd3, '0);
      send_word(ACT_ALLOC, 2'd3, '0);
      send_word(ACT_ALLOC, 2'd2, '0);
      send_word(ACT_FREE,  2'd2, 10'd1);
      send_word(ACT_ALLOC, 2'd2, '0);

      // Fill one file to capacity, hit full, then recycle records at the top
      fidx = FILE_W'($urandom_range(0, NUM_FILES - 1));
      send_word(ACT_RESET, fidx, '0);
      repeat (MAX_RECORDS) send_word(ACT_ALLOC, fidx, REC_W'($urandom));
      repeat (3) send_word(ACT_ALLOC, fidx, REC_W'($urandom));
      send_word(ACT_FREE, fidx, 10'd1023);
      send_word(ACT_FREE, fidx, 10'd512);
      send_word(ACT_ALLOC, fidx, '0);
      send_word(ACT_ALLOC, fidx, '0);
      send_word(ACT_ALLOC, fidx, '0);
      repeat (16) send_word(ACT_FREE, fidx, REC_W'($urandom_range(1, MAX_RECORDS)));
      repeat (20) send_word(ACT_ALLOC, fidx, '0);
      send_word(ACT_RESET, fidx, '0);

      // Random mix: mostly plausible allocate/free traffic, some noise
      for (int n = 0; n < RANDOM_WORDS; n++) begin
         calm = (n >= RANDOM_WORDS - CALM_WORDS);
         pick = $urandom_range(0, 99);
         fidx = FILE_W'($urandom_range(0, NUM_FILES - 1));
         rec  = REC_W'($urandom_range(0, (1 << REC_W) - 1));
         if (pick < 45)
            send_word(ACT_ALLOC, fidx, rec);
         else if (pick < 80)
            send_word(ACT_FREE, fidx, REC_W'($urandom_range(1, 24)));
         else if (pick < 88)
            send_word(ACT_FREE, fidx, rec);
         else if (pick < 91)
            send_word(ACT_FREE, fidx, '0);
         else if (pick < 95)
            send_word(ACT_RESET, fidx, rec);
         else
            send_word(ACT_NOP, fidx, rec);
      end
      req_bus.valid <= 1'b0;

      // Drain outstanding results, then let the pipeline settle
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0 && pending_count == 0)
         $display("[record_free_list_allocator_unit] OK");
      else
         $display("[record_free_list_allocator_unit] ERROR");
      $finish;
   end

endmodule
